/* rtl/hre_pkg.sv */
// hre_pkg: shared constants, types and the digit helper for the hex record encoder
// used by the encoder, its emitter, the checker and the testbench; depends on nothing else
package hre_pkg;

  // buffer sizing
  localparam int MAX_BYTES = 16;
  localparam int IDX_W     = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);
  localparam int ADDR_W    = 16;
  localparam int BYTE_W    = 8;

  // character and field codes
  localparam logic [BYTE_W-1:0] CH_COLON       = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_LF          = 8'd10;
  localparam logic [BYTE_W-1:0] CH_DIGIT_BASE  = 8'd48;
  localparam logic [BYTE_W-1:0] CH_LETTER_BASE = 8'd55;
  localparam logic [BYTE_W-1:0] REC_TYPE_DATA  = 8'h00;
  localparam logic [3:0]        NIB_MAX_DIGIT  = 4'd9;

  // emitter sequence, one state per record field
  typedef enum logic [3:0] {
    EM_IDLE,
    EM_COLON,
    EM_COUNT,
    EM_ADDR_HI,
    EM_ADDR_LO,
    EM_TYPE,
    EM_DATA,
    EM_CHECK,
    EM_LF
  } em_state_e;

  // record handed from the collector to the emitter
  typedef struct packed {
    logic              start;
    logic [CNT_W-1:0]  count;
    logic [ADDR_W-1:0] address;
    logic [BYTE_W-1:0] check;
  } hre_rec_t;

  // uppercase ascii digit for one nibble
  function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
    logic [BYTE_W-1:0] wide;
    wide = {{(BYTE_W-4){1'b0}}, nib};
    if (nib <= NIB_MAX_DIGIT) begin
      return CH_DIGIT_BASE + wide;
    end else begin
      return CH_LETTER_BASE + wide;
    end
  endfunction

endpackage

/* rtl/hre_ram.sv */
// hre_ram: generic single write port, single read port memory
// read data registered; no dependencies
module hre_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/hre_emitter.sv */
// hre_emitter: walks one record field by field and drives the character output register
// depends on hre_pkg; reads buffered bytes from the record memory
module hre_emitter
  import hre_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hre_rec_t          rec_i,
  output logic              busy_o,
  output logic [IDX_W-1:0]  rd_addr_o,
  input  logic [BYTE_W-1:0] rd_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] out_char_o,
  output logic              record_done_o
);

  em_state_e         state_q, state_d;
  logic              lo_q, lo_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  count_q;
  logic [ADDR_W-1:0] address_q;
  logic [BYTE_W-1:0] check_q;
  logic              valid_q;
  logic [BYTE_W-1:0] char_q;
  logic              done_q;
  logic              adv;
  logic              last_byte;
  logic [BYTE_W-1:0] cur_byte;
  logic [3:0]        cur_nib;
  logic [BYTE_W-1:0] char_d;
  logic              done_d;

  // record fields latched at start
  always_ff @(posedge clk_i) begin
    if (rec_i.start) begin
      count_q   <= rec_i.count;
      address_q <= rec_i.address;
      check_q   <= rec_i.check;
    end
  end

  // state, nibble and index registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= EM_IDLE;
      lo_q    <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      lo_q    <= lo_d;
      idx_q   <= idx_d;
    end
  end

  assign adv       = (state_q != EM_IDLE) && (!valid_q || out_ready_i);
  assign last_byte = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);

  // byte and character for the current position
  always_comb begin
    case (state_q)
      EM_COUNT:   cur_byte = BYTE_W'(count_q);
      EM_ADDR_HI: cur_byte = address_q[ADDR_W-1:BYTE_W];
      EM_ADDR_LO: cur_byte = address_q[BYTE_W-1:0];
      EM_TYPE:    cur_byte = REC_TYPE_DATA;
      EM_DATA:    cur_byte = rd_data_i;
      EM_CHECK:   cur_byte = check_q;
      default:    cur_byte = '0;
    endcase
    cur_nib = lo_q ? cur_byte[3:0] : cur_byte[7:4];
    done_d  = 1'b0;
    case (state_q)
      EM_COLON: char_d = CH_COLON;
      EM_LF: begin
        char_d = CH_LF;
        done_d = 1'b1;
      end
      default:  char_d = hex_char(cur_nib);
    endcase
  end

  // next position in the record
  always_comb begin
    state_d = state_q;
    lo_d    = lo_q;
    idx_d   = idx_q;
    if (state_q == EM_IDLE) begin
      if (rec_i.start) begin
        state_d = EM_COLON;
        lo_d    = 1'b0;
        idx_d   = '0;
      end
    end else if (adv) begin
      case (state_q)
        EM_COLON: state_d = EM_COUNT;
        EM_LF: begin
          state_d = EM_IDLE;
          idx_d   = '0;
        end
        default: begin
          lo_d = !lo_q;
          if (lo_q) begin
            case (state_q)
              EM_COUNT:   state_d = EM_ADDR_HI;
              EM_ADDR_HI: state_d = EM_ADDR_LO;
              EM_ADDR_LO: state_d = EM_TYPE;
              EM_TYPE:    state_d = EM_DATA;
              EM_DATA: begin
                idx_d = idx_q + IDX_W'(1);
                if (last_byte) begin
                  state_d = EM_CHECK;
                end
              end
              EM_CHECK:   state_d = EM_LF;
              default:    state_d = EM_IDLE;
            endcase
          end
        end
      endcase
    end
  end

  // output register, refilled whenever it is empty or being taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      char_q <= char_d;
      done_q <= done_d;
    end
  end

  // read address follows the next index, so the registered read returns the byte for the current index
  assign rd_addr_o     = idx_d;
  assign busy_o        = (state_q != EM_IDLE);
  assign out_valid_o   = valid_q;
  assign out_char_o    = char_q;
  assign record_done_o = done_q;

endmodule

/* rtl/hex_record_encoder.sv */
// hex_record_encoder: gathers data bytes and emits type 00 hex records as ascii text
// takes one byte a cycle while collecting; a closing transfer starts the emitter, which then
// loads the colon into its output register; a record of n bytes streams out 12 + 2n characters
// at one per cycle while the receiver is ready, limited by that register; input is held off
// while the emitter is busy; once released, the last line feed may still wait in the register
// reset clears count, address and sum; the byte memory is not cleared
module hex_record_encoder
  import hre_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ADDR_W-1:0] record_address_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic              end_of_record_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] out_char_o,
  output logic              record_done_o
);

  logic [CNT_W-1:0]  byte_count_q, byte_count_d;
  logic [ADDR_W-1:0] held_address_q, held_address_d;
  logic [BYTE_W-1:0] running_sum_q, running_sum_d;
  logic              in_xfer;
  logic              first;
  logic [CNT_W-1:0]  count_next;
  logic              close_rec;
  logic [BYTE_W-1:0] sum_base;
  logic [BYTE_W-1:0] sum_new;
  logic              em_busy;
  logic [IDX_W-1:0]  rd_addr;
  logic [BYTE_W-1:0] rd_data;
  hre_rec_t          rec;

  assign in_ready_o = !em_busy;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign first      = (byte_count_q == '0);
  assign count_next = byte_count_q + CNT_W'(1);
  assign close_rec  = end_of_record_i || (count_next == CNT_W'(MAX_BYTES));

  // running sum of address and data bytes
  always_comb begin
    sum_base = first ? (record_address_i[ADDR_W-1:BYTE_W] + record_address_i[BYTE_W-1:0])
                     : running_sum_q;
    sum_new  = sum_base + data_byte_i;
  end

  // collector state update on an input transfer
  always_comb begin
    byte_count_d   = byte_count_q;
    held_address_d = held_address_q;
    running_sum_d  = running_sum_q;
    rec.start      = 1'b0;
    rec.count      = count_next;
    rec.address    = first ? record_address_i : held_address_q;
    rec.check      = BYTE_W'(0) - (sum_new + BYTE_W'(count_next));
    if (in_xfer) begin
      if (first) begin
        held_address_d = record_address_i;
      end
      if (close_rec) begin
        byte_count_d  = '0;
        running_sum_d = '0;
        rec.start     = 1'b1;
      end else begin
        byte_count_d  = count_next;
        running_sum_d = sum_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q   <= '0;
      held_address_q <= '0;
      running_sum_q  <= '0;
    end else begin
      byte_count_q   <= byte_count_d;
      held_address_q <= held_address_d;
      running_sum_q  <= running_sum_d;
    end
  end

  // record byte memory
  hre_ram #(
    .DEPTH (MAX_BYTES),
    .WIDTH (BYTE_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (in_xfer),
    .waddr_i (byte_count_q[IDX_W-1:0]),
    .wdata_i (data_byte_i),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // character sequencer and output register
  hre_emitter u_emitter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rec_i         (rec),
    .busy_o        (em_busy),
    .rd_addr_o     (rd_addr),
    .rd_data_i     (rd_data),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_char_o    (out_char_o),
    .record_done_o (record_done_o)
  );

`ifndef SYNTHESIS
  // a transfer with the end flag must hold off the input as the record starts to stream out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && end_of_record_i |=> !in_ready_o)
    else $error("input not held off after record close");

  // the done flag marks the line feed only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && record_done_o |-> out_char_o == CH_LF)
    else $error("record done on a character other than line feed");

  // buffered count never reaches the buffer size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_count_q < CNT_W'(MAX_BYTES))
    else $error("byte count overflow");
`endif

endmodule

/* sim/hre_checker.sv */
// hre_checker: watches both channels of the hex record encoder, predicts the record text
// and compares every character transfer; depends on hre_pkg for widths and character codes
module hre_checker
  import hre_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [ADDR_W-1:0] record_address_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic              end_of_record_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [BYTE_W-1:0] out_char_i,
  input  logic              record_done_i,
  output int                mismatches_o,
  output int                pending_o,
  output int                records_o,
  output int                chars_o
);

  // one predicted character of record text
  typedef struct packed {
    logic [BYTE_W-1:0] ch;
    logic              done;
  } text_char_t;

  text_char_t        expected_text[$];
  logic [BYTE_W-1:0] buffered [MAX_BYTES];
  logic [CNT_W-1:0]  fill;
  logic [ADDR_W-1:0] rec_addr;
  logic [BYTE_W-1:0] sum;
  int                errors;
  int                records;
  int                chars;

  // uppercase ascii digit for one nibble
  function automatic logic [BYTE_W-1:0] ascii_nibble(input logic [3:0] nib);
    logic [BYTE_W-1:0] wide;
    wide = {{(BYTE_W-4){1'b0}}, nib};
    if (nib <= NIB_MAX_DIGIT) begin
      return CH_DIGIT_BASE + wide;
    end
    return CH_LETTER_BASE + wide;
  endfunction

  // a byte becomes two digit characters, high nibble first
  task automatic queue_hex_pair(input logic [BYTE_W-1:0] b);
    expected_text.push_back('{ch: ascii_nibble(b[7:4]), done: 1'b0});
    expected_text.push_back('{ch: ascii_nibble(b[3:0]), done: 1'b0});
  endtask

  // fold one accepted byte into the record, emit the text when it closes
  task automatic absorb_byte(input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] data,
                             input logic eor);
    logic [CNT_W-1:0]  count;
    logic [BYTE_W-1:0] total;
    logic [BYTE_W-1:0] cks;
    // address is only taken from the first byte of a record
    if (fill == '0) begin
      rec_addr = addr;
      sum      = addr[15:8] + addr[7:0];
    end
    buffered[fill[IDX_W-1:0]] = data;
    sum            = sum + data;
    count          = fill + 1'b1;
    if (!eor && count < MAX_BYTES) begin
      fill = count;
      return;
    end
    // closed by the end flag or by a full buffer
    total = sum + BYTE_W'(count);
    cks   = 8'h00 - total;
    expected_text.push_back('{ch: CH_COLON, done: 1'b0});
    queue_hex_pair(BYTE_W'(count));
    queue_hex_pair(rec_addr[15:8]);
    queue_hex_pair(rec_addr[7:0]);
    queue_hex_pair(REC_TYPE_DATA);
    for (int i = 0; i < count; i++) begin
      queue_hex_pair(buffered[i]);
    end
    queue_hex_pair(cks);
    expected_text.push_back('{ch: CH_LF, done: 1'b1});
    fill    = '0;
    sum     = '0;
    records = records + 1;
  endtask

  // compare one character transfer against the oldest prediction
  task automatic check_char(input logic [BYTE_W-1:0] ch, input logic done);
    text_char_t want;
    chars = chars + 1;
    if (expected_text.size() == 0) begin
      $error("out_char: no character expected, got %h (record_done %b)", ch, done);
      errors = errors + 1;
      return;
    end
    want = expected_text.pop_front();
    if (ch !== want.ch) begin
      $error("out_char: expected %h, got %h", want.ch, ch);
      errors = errors + 1;
    end
    if (done !== want.done) begin
      $error("record_done: expected %b, got %b", want.done, done);
      errors = errors + 1;
    end
  endtask

  initial begin
    errors       = 0;
    records      = 0;
    chars        = 0;
    fill         = '0;
    rec_addr     = '0;
    sum          = '0;
    mismatches_o = 0;
    pending_o    = 0;
    records_o    = 0;
    chars_o      = 0;
  end

  // outputs are checked before the input of the same edge is folded in
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill     = '0;
      rec_addr = '0;
      sum      = '0;
      expected_text.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        check_char(out_char_i, record_done_i);
      end
      if (in_valid_i && in_ready_i) begin
        absorb_byte(record_address_i, data_byte_i, end_of_record_i);
      end
    end
    mismatches_o <= errors;
    pending_o    <= expected_text.size();
    records_o    <= records;
    chars_o      <= chars;
  end

endmodule

/* sim/hex_record_encoder_tb.sv */
// hex_record_encoder_tb: drives data bytes into the hex record encoder with random gaps
// and output stalls; depends on hre_pkg, hex_record_encoder and hre_checker
module hex_record_encoder_tb
  import hre_pkg::*;
();

  localparam int RANDOM_ITEMS    = 330;
  localparam int SETTLE_CYCLES   = 60;
  localparam int WATCHDOG_CYCLES = 400000;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_ready;
  logic [ADDR_W-1:0] record_address = '0;
  logic [BYTE_W-1:0] data_byte      = '0;
  logic              end_of_record  = 1'b0;
  logic              out_valid;
  logic              out_ready      = 1'b0;
  logic [BYTE_W-1:0] out_char;
  logic              record_done;

  int mismatches;
  int pending;
  int records;
  int chars;
  int items_sent = 0;

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  hex_record_encoder dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .record_address_i (record_address),
    .data_byte_i      (data_byte),
    .end_of_record_i  (end_of_record),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .out_char_o       (out_char),
    .record_done_o    (record_done)
  );

  hre_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .record_address_i (record_address),
    .data_byte_i      (data_byte),
    .end_of_record_i  (end_of_record),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_char_i       (out_char),
    .record_done_i    (record_done),
    .mismatches_o     (mismatches),
    .pending_o        (pending),
    .records_o        (records),
    .chars_o          (chars)
  );

  // receiver stalls: calm stretches, short stalls and the odd long one
  int stall_left = 0;
  int calm_left  = 0;
  always @(posedge clk_i) begin
    int r;
    r = $urandom_range(0, 99);
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left = stall_left - 1;
    end else if (calm_left > 0) begin
      out_ready <= 1'b1;
      calm_left = calm_left - 1;
    end else if (r < 8) begin
      out_ready <= 1'b1;
      calm_left = $urandom_range(20, 80);
    end else if (r < 12) begin
      out_ready  <= 1'b0;
      stall_left = $urandom_range(8, 30);
    end else if (r < 35) begin
      out_ready  <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // sender gap length, mostly short, a few long
  function automatic int pick_gap(input bit quiet);
    int r;
    if (quiet) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 25);
  endfunction

  // one byte transfer; valid stays high across back-to-back bytes
  task automatic push_byte(input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] data,
                           input logic eor, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid       <= 1'b1;
    record_address <= addr;
    data_byte      <= data;
    end_of_record  <= eor;
    do @(posedge clk_i); while (!in_ready);
    items_sent = items_sent + 1;
  endtask

  // one record of random content; later bytes carry junk addresses
  task automatic send_random_record();
    int                len;
    int                r;
    bit                quiet;
    logic [ADDR_W-1:0] addr;
    r     = $urandom_range(0, 99);
    quiet = ($urandom_range(0, 3) == 0);
    if (r < 60) begin
      len = $urandom_range(1, 6);
    end else if (r < 80) begin
      len = $urandom_range(7, MAX_BYTES - 1);
    end else if (r < 90) begin
      len = MAX_BYTES;
    end else begin
      // runs past a full buffer, so the block flushes on its own
      len = $urandom_range(MAX_BYTES + 1, 2 * MAX_BYTES + 8);
    end
    r = $urandom_range(0, 9);
    if (r == 0) begin
      addr = '0;
    end else if (r == 1) begin
      addr = '1;
    end else begin
      addr = ADDR_W'($urandom);
    end
    for (int i = 0; i < len; i++) begin
      push_byte(addr, BYTE_W'($urandom_range(0, 255)), (i == len - 1), pick_gap(quiet));
      addr = ADDR_W'($urandom);
    end
  endtask

  // stimulus and verdict
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes of every field, one byte records
    push_byte(16'h0000, 8'h00, 1'b1, 0);
    push_byte(16'hFFFF, 8'hFF, 1'b1, 0);
    // address ignored on later bytes of a record
    push_byte(16'hA5C3, 8'h9A, 1'b0, 1);
    push_byte(16'h1234, 8'hBF, 1'b0, 0);
    push_byte(16'hFFFF, 8'hE0, 1'b1, 2);
    // buffer full without an end flag, every digit and letter in the data
    for (int i = 0; i < MAX_BYTES; i++) begin
      push_byte(16'h0FF0, BYTE_W'(i * 17), 1'b0, 0);
    end
    // next byte opens a fresh record with its own address
    push_byte(16'h8001, 8'h7E, 1'b1, 0);
    // checksum that wraps to zero
    push_byte(16'h0000, 8'hFF, 1'b1, 3);

    while (items_sent < RANDOM_ITEMS) begin
      send_random_record();
    end
    in_valid <= 1'b0;

    // drain, then let any trailing character show up
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("sent %0d data bytes, %0d records closed by end flag or full buffer",
             items_sent, records);
    $display("checked %0d characters of record text with random gaps and stalls", chars);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(12 * WATCHDOG_CYCLES);
    $display("watchdog expired with %0d characters outstanding", pending);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
